// ----- sv/button_pattern_looper_macros.svh -----
// Assertion macros for the button pattern looper checker.
// Needs clk_i and rst_ni in the scope that uses the macros.
`ifndef BUTTON_PATTERN_LOOPER_MACROS_SVH
`define BUTTON_PATTERN_LOOPER_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define BPL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a signal holds over the next edge while a condition is true.
`define BPL_ASSERT_HOLD(label, cond, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> $stable(sig)) else $error(msg);

`endif

// ----- sv/bpl_pkg.sv -----
// Types and constants of the button pattern looper.
// Used by the channel interfaces, the pattern memory and the top level.
package bpl_pkg;

  localparam int unsigned BUTTONS_W  = 6;
  localparam int unsigned NOTE_W     = 2;
  localparam int unsigned BAR_W      = 8;
  localparam int unsigned LOOP_LEN_W = 10;
  localparam int unsigned DIV_W      = 8;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [LOOP_LEN_W-1:0] LOOP_LEN_RESET = 10'd400;
  localparam logic [DIV_W-1:0]      DIV_RESET      = 8'd5;

  // Register indexes of the configuration channel.
  localparam logic CFG_LOOP_LENGTH  = 1'b0;
  localparam logic CFG_STEP_DIVIDER = 1'b1;

  // Button bits.
  localparam logic [BUTTONS_W-1:0] BTN_NONE = 6'h00;
  localparam logic [BUTTONS_W-1:0] BTN_NEW  = 6'h20;
  localparam logic [BUTTONS_W-1:0] BTN_REC  = 6'h10;
  localparam logic [BUTTONS_W-1:0] BTN_PLAY = 6'h08;
  localparam logic [BUTTONS_W-1:0] BTN_D1   = 6'h04;
  localparam logic [BUTTONS_W-1:0] BTN_D2   = 6'h02;
  localparam logic [BUTTONS_W-1:0] BTN_D3   = 6'h01;

  localparam logic [NOTE_W-1:0] NOTE_SILENT = 2'd0;
  localparam logic [NOTE_W-1:0] NOTE_D1     = 2'd1;
  localparam logic [NOTE_W-1:0] NOTE_D2     = 2'd2;
  localparam logic [NOTE_W-1:0] NOTE_D3     = 2'd3;

  // Progress bar codes with one to eight lit segments.
  localparam logic [7:0][BAR_W-1:0] BAR_CODES = {
    8'hFF, 8'h7F, 8'h3F, 8'h1F, 8'h0F, 8'h07, 8'h03, 8'h01
  };
  localparam logic [BAR_W-1:0] BAR_OFF = 8'h00;

  typedef enum logic [2:0] {
    BM_INIT = 3'd0,
    BM_IDLE = 3'd1,
    BM_REC  = 3'd2,
    BM_NEW  = 3'd3,
    BM_PLAY = 3'd4,
    BM_D1   = 3'd5,
    BM_D2   = 3'd6,
    BM_D3   = 3'd7
  } bm_e;

  typedef enum logic [1:0] {
    LM_INIT = 2'd0,
    LM_IDLE = 2'd1,
    LM_LOOP = 2'd2
  } lm_e;

  // Where the sounding note of a request comes from once it is resolved.
  typedef enum logic [1:0] {
    SND_KEEP  = 2'd0,
    SND_VALUE = 2'd1,
    SND_MEM   = 2'd2
  } snd_src_e;

  typedef struct packed {
    snd_src_e          src;
    logic [NOTE_W-1:0] value;
    logic [BAR_W-1:0]  bar;
    logic              playing;
    logic              recording;
  } stage_t;

endpackage

// ----- sv/bpl_in_if.sv -----
// Input channel of the button pattern looper: one button sample per request.
// Depends on bpl_pkg for the field width.
interface bpl_in_if;
  logic                           valid;
  logic                           ready;
  logic [bpl_pkg::BUTTONS_W-1:0]  buttons;

  modport source (output valid, output buttons, input ready);
  modport sink   (input valid, input buttons, output ready);
endinterface

// ----- sv/bpl_out_if.sv -----
// Output channel of the button pattern looper: one result per request.
// Depends on bpl_pkg for the field widths.
interface bpl_out_if;
  logic                        valid;
  logic                        ready;
  logic [bpl_pkg::NOTE_W-1:0]  sound_note;
  logic [bpl_pkg::BAR_W-1:0]   led_bar;
  logic                        playing;
  logic                        recording;

  modport source (output valid, output sound_note, output led_bar, output playing,
                  output recording, input ready);
  modport sink   (input valid, input sound_note, input led_bar, input playing,
                  input recording, output ready);
endinterface

// ----- sv/bpl_cfg_if.sv -----
// Configuration write channel of the button pattern looper.
// Depends on bpl_pkg for the data width.
interface bpl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic                             index;
  logic [bpl_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/bpl_pattern_ram.sv -----
// Pattern memory: one write port, one read port with registered read data.
// Depends on bpl_pkg for the note width.
module bpl_pattern_ram #(
  parameter int unsigned DEPTH = 512
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [bpl_pkg::NOTE_W-1:0]    wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic [bpl_pkg::NOTE_W-1:0]    rdata_o
);

  logic [bpl_pkg::NOTE_W-1:0] mem_q [DEPTH];
  logic [bpl_pkg::NOTE_W-1:0] rdata_q;

  // A read and a write of the same entry in one cycle return the old value.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/button_pattern_looper.sv -----
// Button pattern looper. A taken request is held in the stage one register and its result
// then in the output register. Throughput: one request per cycle; the pattern memory port
// pair (one read and one write per cycle) sets that figure, and a full output register
// stalls the input. Reset: all modes return to init, the flags, note and bar clear, and a
// clearing pass writes silence into every pattern entry while no request is taken.
module button_pattern_looper #(
  parameter int unsigned PATTERN_DEPTH = 512
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpl_in_if.sink    in_i,
  bpl_out_if.source out_o,
  bpl_cfg_if.sink   cfg_i
);

  // Address width, width of a length that may equal the depth, and a width that
  // holds both the configured loop length and the depth for the clamp.
  localparam int unsigned AW = $clog2(PATTERN_DEPTH);
  localparam int unsigned LW = $clog2(PATTERN_DEPTH + 1);
  localparam int unsigned CW = (LW > bpl_pkg::LOOP_LEN_W) ? LW : bpl_pkg::LOOP_LEN_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. The channel is always ready; the user must write
  // only while the block is idle, which the block itself does not enforce.
  // ---------------------------------------------------------------------------
  logic [bpl_pkg::LOOP_LEN_W-1:0] loop_length_q;
  logic [bpl_pkg::DIV_W-1:0]      step_divider_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_length_q  <= bpl_pkg::LOOP_LEN_RESET;
      step_divider_q <= bpl_pkg::DIV_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bpl_pkg::CFG_LOOP_LENGTH:  loop_length_q  <= cfg_i.data;
        bpl_pkg::CFG_STEP_DIVIDER: step_divider_q <= cfg_i.data[bpl_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass. After reset every pattern entry is written with silence,
  // one entry a cycle, before the first request is taken.
  // ---------------------------------------------------------------------------
  logic [AW-1:0] clr_addr_q;
  logic          clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(PATTERN_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. Stage zero is the accept cycle: all machine state is
  // updated there and the pattern memory is read and written. Stage one waits
  // for the read data and resolves the sounding note into the output register.
  // ---------------------------------------------------------------------------
  logic            s1_valid_q;
  bpl_pkg::stage_t s1_q;
  bpl_pkg::stage_t s1_d;
  logic            out_valid_q;
  logic            s1_move;
  logic            accept;

  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !clr_busy_q && (!s1_valid_q || s1_move);
  assign accept     = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------------
  // Machine state.
  // ---------------------------------------------------------------------------
  bpl_pkg::bm_e                bm_q, bm_d;
  bpl_pkg::lm_e                pm_q, pm_d;
  bpl_pkg::lm_e                rm_q, rm_d;
  logic [AW-1:0]               ppos_q, ppos_d;
  logic [AW-1:0]               rpos_q, rpos_d;
  logic                        play_on_q, play_on_d;
  logic                        rec_on_q, rec_on_d;
  logic [bpl_pkg::NOTE_W-1:0]  held_q, held_d;
  logic [bpl_pkg::BAR_W-1:0]   bar_q, bar_d;
  logic [bpl_pkg::DIV_W-1:0]   phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bm_q      <= bpl_pkg::BM_INIT;
      pm_q      <= bpl_pkg::LM_INIT;
      rm_q      <= bpl_pkg::LM_INIT;
      ppos_q    <= '0;
      rpos_q    <= '0;
      play_on_q <= 1'b0;
      rec_on_q  <= 1'b0;
      held_q    <= bpl_pkg::NOTE_SILENT;
      bar_q     <= bpl_pkg::BAR_OFF;
      phase_q   <= '0;
    end else if (accept) begin
      bm_q      <= bm_d;
      pm_q      <= pm_d;
      rm_q      <= rm_d;
      ppos_q    <= ppos_d;
      rpos_q    <= rpos_d;
      play_on_q <= play_on_d;
      rec_on_q  <= rec_on_d;
      held_q    <= held_d;
      bar_q     <= bar_d;
      phase_q   <= phase_d;
    end
  end

  // Effective loop length: zero acts as one, and a length above the depth is
  // clamped to the depth.
  logic [CW-1:0] len_ext;
  logic [LW-1:0] len;

  always_comb begin
    len_ext = CW'(loop_length_q);
    if (len_ext == '0) begin
      len_ext = CW'(1);
    end
    if (len_ext > CW'(PATTERN_DEPTH)) begin
      len_ext = CW'(PATTERN_DEPTH);
    end
    len = len_ext[LW-1:0];
  end

  // Step timing. A step is due when the phase is zero; the phase then counts
  // up to the divider and wraps, so a lowered divider wraps at once.
  logic                       due;
  logic [bpl_pkg::DIV_W-1:0]  div;
  logic [bpl_pkg::DIV_W:0]    phase_inc;

  always_comb begin
    due       = (phase_q == '0);
    div       = (step_divider_q == '0) ? bpl_pkg::DIV_W'(1) : step_divider_q;
    phase_inc = {1'b0, phase_q} + (bpl_pkg::DIV_W + 1)'(1);
    phase_d   = (phase_inc >= {1'b0, div}) ? '0 : phase_inc[bpl_pkg::DIV_W-1:0];
  end

  // Progress bar for the play and record positions. With q the length over
  // eight, the bar shows the smallest k with position <= k*q; with no such k
  // the bar keeps its value, which the hit flags carry.
  logic [LW-1:0]              seg;
  logic [bpl_pkg::BAR_W-1:0]  pbar, rbar;
  logic                       phit, rhit;

  always_comb begin
    seg  = len >> 3;
    pbar = bpl_pkg::BAR_OFF;
    rbar = bpl_pkg::BAR_OFF;
    phit = 1'b0;
    rhit = 1'b0;
    for (int k = 8; k >= 1; k--) begin
      if (LW'(ppos_q) <= seg * LW'(k)) begin
        phit = 1'b1;
        pbar = bpl_pkg::BAR_CODES[k-1];
      end
      if (LW'(rpos_q) <= seg * LW'(k)) begin
        rhit = 1'b1;
        rbar = bpl_pkg::BAR_CODES[k-1];
      end
    end
  end

  // Next positions, wrapping to zero at the end of the loop.
  logic [LW-1:0] ppos_inc, rpos_inc;
  logic [AW-1:0] ppos_adv, rpos_adv;

  always_comb begin
    ppos_inc = LW'(ppos_q) + LW'(1);
    rpos_inc = LW'(rpos_q) + LW'(1);
    ppos_adv = (ppos_inc < len) ? ppos_inc[AW-1:0] : '0;
    rpos_adv = (rpos_inc < len) ? rpos_inc[AW-1:0] : '0;
  end

  // Button machine, then the play and record steps. The memory read for the
  // play step is issued here and resolved in stage one; the record write is
  // issued here too, after the read of the same cycle.
  logic [bpl_pkg::BUTTONS_W-1:0] b;
  logic                          rec_we;

  always_comb begin
    b         = in_i.buttons;
    bm_d      = bm_q;
    held_d    = held_q;
    play_on_d = play_on_q;
    rec_on_d  = rec_on_q;

    case (bm_q)
      bpl_pkg::BM_INIT: begin
        bm_d = bpl_pkg::BM_IDLE;
      end
      bpl_pkg::BM_IDLE: begin
        if (b == bpl_pkg::BTN_D3)        bm_d = bpl_pkg::BM_D3;
        else if (b == bpl_pkg::BTN_D2)   bm_d = bpl_pkg::BM_D2;
        else if (b == bpl_pkg::BTN_D1)   bm_d = bpl_pkg::BM_D1;
        else if (b == bpl_pkg::BTN_PLAY) bm_d = bpl_pkg::BM_PLAY;
        else if (b == bpl_pkg::BTN_REC)  bm_d = bpl_pkg::BM_REC;
        else if (b == bpl_pkg::BTN_NEW)  bm_d = bpl_pkg::BM_NEW;
      end
      bpl_pkg::BM_REC: begin
        if (b == bpl_pkg::BTN_NONE) begin
          rec_on_d  = !rec_on_q;
          play_on_d = 1'b0;
          bm_d      = bpl_pkg::BM_IDLE;
        end
      end
      bpl_pkg::BM_PLAY: begin
        if (b == bpl_pkg::BTN_NONE) begin
          play_on_d = !play_on_q;
          if (!play_on_q) begin
            rec_on_d = 1'b0;
          end
          bm_d = bpl_pkg::BM_IDLE;
        end
      end
      bpl_pkg::BM_D1: begin
        if (b == bpl_pkg::BTN_D1) begin
          held_d = bpl_pkg::NOTE_D1;
        end else if (b == bpl_pkg::BTN_NONE) begin
          held_d = bpl_pkg::NOTE_SILENT;
          bm_d   = bpl_pkg::BM_IDLE;
        end
      end
      bpl_pkg::BM_D2: begin
        if (b == bpl_pkg::BTN_D2) begin
          held_d = bpl_pkg::NOTE_D2;
        end else if (b == bpl_pkg::BTN_NONE) begin
          held_d = bpl_pkg::NOTE_SILENT;
          bm_d   = bpl_pkg::BM_IDLE;
        end
      end
      bpl_pkg::BM_D3: begin
        if (b == bpl_pkg::BTN_D3) begin
          held_d = bpl_pkg::NOTE_D3;
        end else if (b == bpl_pkg::BTN_NONE) begin
          held_d = bpl_pkg::NOTE_SILENT;
          bm_d   = bpl_pkg::BM_IDLE;
        end
      end
      default: begin
        // The new button state: holding new alone moves on to drum three.
        if (b == bpl_pkg::BTN_NEW)       bm_d = bpl_pkg::BM_D3;
        else if (b == bpl_pkg::BTN_NONE) bm_d = bpl_pkg::BM_IDLE;
      end
    endcase

    // While not playing, the held note sounds directly.
    s1_d.src   = play_on_d ? bpl_pkg::SND_KEEP : bpl_pkg::SND_VALUE;
    s1_d.value = held_d;

    pm_d   = pm_q;
    rm_d   = rm_q;
    ppos_d = ppos_q;
    rpos_d = rpos_q;
    bar_d  = bar_q;
    rec_we = 1'b0;

    if (due) begin
      case (pm_q)
        bpl_pkg::LM_INIT: begin
          bar_d  = bpl_pkg::BAR_OFF;
          ppos_d = '0;
          pm_d   = bpl_pkg::LM_IDLE;
        end
        bpl_pkg::LM_IDLE: begin
          if (play_on_d) pm_d = bpl_pkg::LM_LOOP;
        end
        bpl_pkg::LM_LOOP: begin
          if (phit) bar_d = pbar;
          ppos_d = ppos_adv;
          if (play_on_d) begin
            s1_d.src = bpl_pkg::SND_MEM;
          end else begin
            s1_d.src   = bpl_pkg::SND_VALUE;
            s1_d.value = bpl_pkg::NOTE_SILENT;
            pm_d       = bpl_pkg::LM_INIT;
          end
        end
        default: begin
          pm_d = bpl_pkg::LM_INIT;
        end
      endcase

      // The record step follows the play step, so its bar value stands.
      case (rm_q)
        bpl_pkg::LM_INIT: begin
          bar_d  = bpl_pkg::BAR_OFF;
          rpos_d = '0;
          rm_d   = bpl_pkg::LM_IDLE;
        end
        bpl_pkg::LM_IDLE: begin
          if (rec_on_d) rm_d = bpl_pkg::LM_LOOP;
        end
        bpl_pkg::LM_LOOP: begin
          if (rhit) bar_d = rbar;
          rec_we = 1'b1;
          rpos_d = rpos_adv;
          if (!rec_on_d) rm_d = bpl_pkg::LM_INIT;
        end
        default: begin
          rm_d = bpl_pkg::LM_INIT;
        end
      endcase
    end

    s1_d.bar       = bar_d;
    s1_d.playing   = play_on_d;
    s1_d.recording = rec_on_d;
  end

  // ---------------------------------------------------------------------------
  // Pattern memory. The clearing pass owns the write port until it is done.
  // ---------------------------------------------------------------------------
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [bpl_pkg::NOTE_W-1:0] mem_wdata;
  logic [bpl_pkg::NOTE_W-1:0] mem_rdata;

  assign mem_we    = clr_busy_q || (accept && rec_we);
  assign mem_waddr = clr_busy_q ? clr_addr_q : rpos_q;
  assign mem_wdata = clr_busy_q ? bpl_pkg::NOTE_SILENT : held_d;

  bpl_pattern_ram #(
    .DEPTH (PATTERN_DEPTH)
  ) u_pattern_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (ppos_q),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage one and the output register. The sounding note register doubles as
  // the machine's sounding state: a request that keeps the note copies the
  // value of the request before it.
  // ---------------------------------------------------------------------------
  logic [bpl_pkg::NOTE_W-1:0] out_note_q, out_note_d;
  logic [bpl_pkg::BAR_W-1:0]  out_bar_q;
  logic                       out_play_q;
  logic                       out_rec_q;

  always_comb begin
    case (s1_q.src)
      bpl_pkg::SND_VALUE: out_note_d = s1_q.value;
      bpl_pkg::SND_MEM:   out_note_d = mem_rdata;
      default:            out_note_d = out_note_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_q       <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_q       <= s1_d;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_note_q  <= bpl_pkg::NOTE_SILENT;
      out_bar_q   <= bpl_pkg::BAR_OFF;
      out_play_q  <= 1'b0;
      out_rec_q   <= 1'b0;
    end else begin
      if (s1_move) begin
        out_valid_q <= 1'b1;
        out_note_q  <= out_note_d;
        out_bar_q   <= s1_q.bar;
        out_play_q  <= s1_q.playing;
        out_rec_q   <= s1_q.recording;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sound_note = out_note_q;
  assign out_o.led_bar    = out_bar_q;
  assign out_o.playing    = out_play_q;
  assign out_o.recording  = out_rec_q;

endmodule

// ----- sv/bpl_checker.sv -----
// Port checker for the button pattern looper, bound to its top level.
// Depends on bpl_pkg and the assertion macros header.
`include "button_pattern_looper_macros.svh"

module bpl_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [bpl_pkg::NOTE_W-1:0]  sound_note_i,
  input logic [bpl_pkg::BAR_W-1:0]   led_bar_i,
  input logic                        playing_i,
  input logic                        recording_i
);

  logic stalled;
  logic [bpl_pkg::BAR_W-1:0] bar_plus;

  assign stalled  = out_valid_i && !out_ready_i;
  assign bar_plus = led_bar_i + bpl_pkg::BAR_W'(1);

  // A stalled result stays offered.
  `BPL_ASSERT(a_out_hold, stalled |=> out_valid_i, "result dropped while stalled")

  // A stalled result keeps its note.
  `BPL_ASSERT_HOLD(a_note_hold, stalled, sound_note_i, "note changed while stalled")

  // The bar is always a thermometer code from the lowest segment.
  `BPL_ASSERT(a_bar_therm, out_valid_i |-> ((led_bar_i & bar_plus) == '0),
              "bar is not a thermometer code")

  // Starting play stops recording and starting record stops play.
  `BPL_ASSERT(a_modes_excl, out_valid_i |-> !(playing_i && recording_i),
              "play and record flags both set")

endmodule

bind button_pattern_looper bpl_checker u_bpl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .sound_note_i (out_o.sound_note),
  .led_bar_i    (out_o.led_bar),
  .playing_i    (out_o.playing),
  .recording_i  (out_o.recording)
);
